### rtl/inoc_pkg.sv
// Shared types and constants for the inode cache lookup/allocate block.
// Used by inode_cache_lookup_allocate and the testbench files; no dependencies.
`timescale 1ns / 1ps

package inoc_pkg;

    localparam int CACHE_ENTRIES_DEF    = 64;
    localparam int INODES_PER_BLOCK_DEF = 8;
    localparam int NUMBER_W             = 32;
    localparam int REFS_W               = 16;
    localparam int SLOT_W               = 6;
    localparam logic [REFS_W-1:0] REFS_MAX = '1;

    typedef enum logic {
        OP_GET  = 1'b0,
        OP_MARK = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_HIT_LOADED   = 3'd0,
        ST_HIT_UNLOADED = 3'd1,
        ST_CLAIMED      = 3'd2,
        ST_FULL         = 3'd3,
        ST_MARKED       = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_op                 op;
        logic [NUMBER_W-1:0] inode_number;
        logic [SLOT_W-1:0]   slot_index;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   slot;
        logic [REFS_W-1:0]   ref_count;
        logic [NUMBER_W-1:0] inode_block;
        logic [2:0]          index_in_block;
    } t_rsp;

    // one cache slot as stored in the table memory
    typedef struct packed {
        logic [NUMBER_W-1:0] number;
        logic [REFS_W-1:0]   refs;
        logic                loaded;
    } t_entry;

endpackage

### rtl/inoc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module inoc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/inode_cache_lookup_allocate.sv
// Inode cache lookup/allocate: top level. Uses inoc_pkg and inoc_ram.
// Get: one table entry per cycle from slot 0 up, stops on a hit; the response loads
//   once the scan and the block multiply are done and the response register is free.
// Mark-loaded: read, write back marked loaded, block multiply; a slot past the table
//   goes straight to the response. Next request is taken the cycle after the response
//   loads; a held response stalls. After reset a clearing pass zeroes every slot.
`timescale 1ns / 1ps

module inode_cache_lookup_allocate #(
    parameter int CACHE_ENTRIES    = inoc_pkg::CACHE_ENTRIES_DEF,
    parameter int INODES_PER_BLOCK = inoc_pkg::INODES_PER_BLOCK_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [31:0]     i_cfg_wr_data,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  inoc_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output inoc_pkg::t_rsp  o_rsp
);

    localparam int AW    = $clog2(CACHE_ENTRIES);
    localparam int EW    = $bits(inoc_pkg::t_entry);
    localparam int DW    = $clog2(INODES_PER_BLOCK) + 1;
    localparam int NW    = inoc_pkg::NUMBER_W;
    // reciprocal of the block size, truncated plus one; exact for 32-bit numbers and
    // block sizes up to 2**RECIP_PREC
    localparam int RECIP_PREC = 6;
    localparam int RECIP_SH   = NW + RECIP_PREC;
    localparam int LO_W       = 20;
    localparam int HI_W       = RECIP_SH + 1 - LO_W;
    localparam int ACC_W      = NW + RECIP_SH;
    localparam int DIV_STEPS  = 3;
    localparam int CNT_W      = 2;
    localparam logic [RECIP_SH:0] RECIP =
        (RECIP_SH+1)'((64'd1 << RECIP_SH) / 64'(INODES_PER_BLOCK) + 64'd1);
    localparam logic [LO_W-1:0] RECIP_LO = RECIP[LO_W-1:0];
    localparam logic [HI_W-1:0] RECIP_HI = RECIP[RECIP_SH:LO_W];
    localparam logic [NW-1:0]   DIV_C    = NW'(INODES_PER_BLOCK);

    inoc_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_chk, n_chk;
    logic             r_have_free, n_have_free;
    logic [AW-1:0]    r_free, n_free;
    logic [NW-1:0]    r_number, n_number;
    inoc_pkg::t_status r_status, n_status;
    logic [inoc_pkg::SLOT_W-1:0] r_rsp_slot, n_rsp_slot;
    logic [inoc_pkg::REFS_W-1:0] r_refs, n_refs;
    logic             r_locate, n_locate;
    logic [31:0]      r_area;

    // block / index unit
    logic [NW-1:0]      r_dnum;
    logic [ACC_W-1:0]   r_acc;
    logic [NW-1:0]      r_quo;
    logic [DW-1:0]      r_rem;
    logic [CNT_W-1:0]   r_div_cnt;
    logic               w_div_busy;
    logic               w_div_start;
    logic [NW-1:0]      w_div_in;
    logic [LO_W-1:0]    w_mul_b;
    logic [NW+LO_W-1:0] w_mul;
    logic [NW-1:0]      w_quo;
    logic [NW-1:0]      w_qd;
    logic [NW-1:0]      w_rem_full;
    logic [31:0]        w_rem_ext;

    // memory port
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    inoc_pkg::t_entry w_wdata;
    logic [AW-1:0]    w_raddr;
    logic [EW-1:0]    w_rdata;
    inoc_pkg::t_entry w_rd;

    logic             w_load;
    logic             w_hit;
    logic             w_free_now;
    logic             w_last;
    logic [inoc_pkg::REFS_W-1:0] w_refs_inc;
    logic [31:0]      w_sidx_ext;
    logic [31:0]      w_chk_ext;
    logic [31:0]      w_free_ext;
    logic             w_sidx_oor;

    inoc_pkg::t_rsp   r_rsp;
    logic             r_rsp_valid;

    inoc_ram #(
        .WIDTH (EW),
        .DEPTH (CACHE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd       = inoc_pkg::t_entry'(w_rdata);
    assign w_hit      = (w_rd.refs != '0) && (w_rd.number == r_number);
    assign w_free_now = (w_rd.refs == '0);
    assign w_last     = (r_chk == AW'(CACHE_ENTRIES - 1));
    assign w_refs_inc = (w_rd.refs == inoc_pkg::REFS_MAX) ? w_rd.refs
                                                          : w_rd.refs + 1'b1;
    assign w_sidx_ext = 32'(i_req.slot_index);
    assign w_sidx_oor = (w_sidx_ext >= 32'(CACHE_ENTRIES));
    assign w_chk_ext  = 32'(r_chk);
    assign w_free_ext = 32'(r_free);

    // number / block size by reciprocal multiply: low half of the reciprocal,
    // then high half accumulated, then quotient and remainder
    assign w_div_busy = (r_div_cnt != '0);
    assign w_mul_b    = (r_div_cnt == CNT_W'(DIV_STEPS)) ? RECIP_LO : LO_W'(RECIP_HI);
    assign w_mul      = r_dnum * w_mul_b;
    assign w_quo      = r_acc[RECIP_SH +: NW];
    assign w_qd       = w_quo * DIV_C;
    assign w_rem_full = r_dnum - w_qd;
    assign w_rem_ext  = 32'(r_rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (w_div_start) begin
            r_div_cnt <= CNT_W'(DIV_STEPS);
        end else if (w_div_busy) begin
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_div_start) begin
            r_dnum <= w_div_in;
        end else if (w_div_busy) begin
            if (r_div_cnt == CNT_W'(DIV_STEPS)) begin
                r_acc <= ACC_W'(w_mul);
            end else if (r_div_cnt == CNT_W'(DIV_STEPS - 1)) begin
                r_acc <= r_acc + (ACC_W'(w_mul) << LO_W);
            end else begin
                r_quo <= w_quo;
                r_rem <= w_rem_full[DW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area <= '0;
        end else if (i_cfg_wr_en) begin
            r_area <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= inoc_pkg::S_CLEAR;
            r_chk       <= '0;
            r_have_free <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chk       <= n_chk;
            r_have_free <= n_have_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_free     <= n_free;
        r_number   <= n_number;
        r_status   <= n_status;
        r_rsp_slot <= n_rsp_slot;
        r_refs     <= n_refs;
        r_locate   <= n_locate;
    end

    always_comb begin
        n_state     = r_state;
        n_chk       = r_chk;
        n_have_free = r_have_free;
        n_free      = r_free;
        n_number    = r_number;
        n_status    = r_status;
        n_rsp_slot  = r_rsp_slot;
        n_refs      = r_refs;
        n_locate    = r_locate;
        o_req_ready = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_chk;
        w_wdata     = '0;
        w_raddr     = r_chk + 1'b1;
        w_div_start = 1'b0;
        w_div_in    = i_req.inode_number;
        w_load      = 1'b0;

        unique case (r_state)
            inoc_pkg::S_CLEAR: begin
                w_we  = 1'b1;
                n_chk = r_chk + 1'b1;
                if (w_last) begin
                    n_state = inoc_pkg::S_IDLE;
                end
            end
            inoc_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_rsp_slot = i_req.slot_index;
                    if (i_req.op == inoc_pkg::OP_GET) begin
                        n_number    = i_req.inode_number;
                        n_chk       = '0;
                        n_have_free = 1'b0;
                        n_locate    = 1'b1;
                        w_raddr     = '0;
                        w_div_start = 1'b1;
                        n_state     = inoc_pkg::S_SCAN;
                    end else if (w_sidx_oor) begin
                        n_status = inoc_pkg::ST_MARKED;
                        n_refs   = '0;
                        n_locate = 1'b0;
                        n_state  = inoc_pkg::S_FINISH;
                    end else begin
                        n_chk   = w_sidx_ext[AW-1:0];
                        w_raddr = w_sidx_ext[AW-1:0];
                        n_state = inoc_pkg::S_MARK;
                    end
                end
            end
            inoc_pkg::S_SCAN: begin
                // data for slot r_chk is on the read port this cycle
                n_chk = r_chk + 1'b1;
                if (w_hit) begin
                    w_we       = 1'b1;
                    w_waddr    = r_chk;
                    w_wdata    = '{number: r_number, refs: w_refs_inc,
                                   loaded: w_rd.loaded};
                    n_status   = w_rd.loaded ? inoc_pkg::ST_HIT_LOADED
                                             : inoc_pkg::ST_HIT_UNLOADED;
                    n_rsp_slot = w_chk_ext[inoc_pkg::SLOT_W-1:0];
                    n_refs     = w_refs_inc;
                    n_state    = inoc_pkg::S_FINISH;
                end else begin
                    if (!r_have_free && w_free_now) begin
                        n_have_free = 1'b1;
                        n_free      = r_chk;
                    end
                    if (w_last) begin
                        n_state = inoc_pkg::S_FINISH;
                        if (r_have_free || w_free_now) begin
                            w_we       = 1'b1;
                            w_waddr    = r_have_free ? r_free : r_chk;
                            w_wdata    = '{number: r_number, refs: 16'd1,
                                           loaded: 1'b0};
                            n_status   = inoc_pkg::ST_CLAIMED;
                            n_rsp_slot = r_have_free ? w_free_ext[inoc_pkg::SLOT_W-1:0]
                                                     : w_chk_ext[inoc_pkg::SLOT_W-1:0];
                            n_refs     = 16'd1;
                        end else begin
                            n_status   = inoc_pkg::ST_FULL;
                            n_rsp_slot = '0;
                            n_refs     = '0;
                        end
                    end
                end
            end
            inoc_pkg::S_MARK: begin
                w_we        = 1'b1;
                w_waddr     = r_chk;
                w_wdata     = '{number: w_rd.number, refs: w_rd.refs, loaded: 1'b1};
                w_div_start = 1'b1;
                w_div_in    = w_rd.number;
                n_status    = inoc_pkg::ST_MARKED;
                n_refs      = w_rd.refs;
                n_locate    = 1'b1;
                n_state     = inoc_pkg::S_FINISH;
            end
            inoc_pkg::S_FINISH: begin
                if (!w_div_busy && (!r_rsp_valid || i_rsp_ready)) begin
                    w_load  = 1'b1;
                    n_state = inoc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = inoc_pkg::S_IDLE;
            end
        endcase
    end

    // response register parts the scan from the consumer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_load) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rsp.status         <= r_status;
            r_rsp.slot           <= r_rsp_slot;
            r_rsp.ref_count      <= r_refs;
            r_rsp.inode_block    <= r_locate ? r_area + r_quo : '0;
            r_rsp.index_in_block <= r_locate ? w_rem_ext[2:0] : '0;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == inoc_pkg::S_IDLE) |-> !w_we)
        else $error("table written while idle");

    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider restarted while busy");

    a_rsp_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> ($past(r_state) == inoc_pkg::S_FINISH))
        else $error("response raised outside finish");

    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == inoc_pkg::S_CLEAR) |-> !o_req_ready)
        else $error("request taken during clearing pass");

endmodule

### tb/inode_cache_checker.sv
// Checker for inode_cache_lookup_allocate: watches the config, request and response
// channels, keeps its own copy of the inode table and compares every response.
// Depends on inoc_pkg for the request/response structs and the status codes.
`timescale 1ns / 1ps

module inode_cache_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [31:0]      i_cfg_wr_data,
    input  logic             i_req_valid,
    input  logic             i_req_ready,
    input  inoc_pkg::t_req   i_req,
    input  logic             i_rsp_valid,
    input  logic             i_rsp_ready,
    input  inoc_pkg::t_rsp   i_rsp,
    output int               o_fail_count,
    output int               o_pending
);
    import inoc_pkg::*;

    localparam int                  ENTRIES   = CACHE_ENTRIES_DEF;
    localparam logic [NUMBER_W-1:0] PER_BLOCK = INODES_PER_BLOCK_DEF;

    logic [NUMBER_W-1:0] area_start;
    logic [NUMBER_W-1:0] slot_number [ENTRIES];
    logic [REFS_W-1:0]   slot_refs   [ENTRIES];
    logic                slot_loaded [ENTRIES];
    t_rsp                awaited_rsps [$];
    int                  fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic t_rsp locate(t_status st, logic [SLOT_W-1:0] slot,
                                    logic [REFS_W-1:0] refs, logic [NUMBER_W-1:0] number);
        t_rsp res;
        res.status         = st;
        res.slot           = slot;
        res.ref_count      = refs;
        res.inode_block    = area_start + number / PER_BLOCK;
        res.index_in_block = 3'(number % PER_BLOCK);
        return res;
    endfunction

    // updates the table copy and returns the response the block owes
    function automatic t_rsp cache_access(t_req r);
        t_rsp res;
        int   hit;
        int   free_slot;
        hit       = -1;
        free_slot = -1;
        if (r.op == OP_MARK) begin
            if (int'(r.slot_index) >= ENTRIES) begin
                res        = '0;
                res.status = ST_MARKED;
                res.slot   = r.slot_index;
                return res;
            end
            slot_loaded[r.slot_index] = 1'b1;
            return locate(ST_MARKED, r.slot_index, slot_refs[r.slot_index],
                          slot_number[r.slot_index]);
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_refs[i] != '0 && slot_number[i] == r.inode_number) begin
                hit = i;
                break;
            end
            if (free_slot < 0 && slot_refs[i] == '0)
                free_slot = i;
        end
        if (hit >= 0) begin
            if (slot_refs[hit] != REFS_MAX)
                slot_refs[hit] = slot_refs[hit] + 1'b1;
            return locate(slot_loaded[hit] ? ST_HIT_LOADED : ST_HIT_UNLOADED,
                          SLOT_W'(hit), slot_refs[hit], r.inode_number);
        end
        if (free_slot < 0)
            return locate(ST_FULL, '0, '0, r.inode_number);
        slot_number[free_slot] = r.inode_number;
        slot_refs[free_slot]   = REFS_W'(1);
        slot_loaded[free_slot] = 1'b0;
        return locate(ST_CLAIMED, SLOT_W'(free_slot), REFS_W'(1), r.inode_number);
    endfunction

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t checker: %s mismatch, expected %h actual %h",
                     $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            area_start = '0;
            for (int i = 0; i < ENTRIES; i++) begin
                slot_number[i] = '0;
                slot_refs[i]   = '0;
                slot_loaded[i] = 1'b0;
            end
            awaited_rsps.delete();
        end else begin
            if (i_cfg_wr_en)
                area_start = i_cfg_wr_data;
            if (i_req_valid && i_req_ready)
                awaited_rsps.push_back(cache_access(i_req));
            if (i_rsp_valid && i_rsp_ready) begin
                if (awaited_rsps.size() == 0) begin
                    $display("%0t checker: response with none expected, actual %h",
                             $time, i_rsp);
                    fail_count++;
                end else begin
                    want = awaited_rsps.pop_front();
                    check_field("status", 32'(want.status), 32'(i_rsp.status));
                    check_field("slot", 32'(want.slot), 32'(i_rsp.slot));
                    check_field("ref_count", 32'(want.ref_count), 32'(i_rsp.ref_count));
                    check_field("inode_block", want.inode_block, i_rsp.inode_block);
                    check_field("index_in_block", 32'(want.index_in_block),
                                32'(i_rsp.index_in_block));
                end
            end
        end
        o_pending <= awaited_rsps.size();
    end

endmodule

### tb/tb_inode_cache_lookup_allocate.sv
// Testbench top for inode_cache_lookup_allocate: clock, reset, config writes and
// request/response traffic; inode_cache_checker does the prediction and compare.
// Depends on inoc_pkg, the block and tb/inode_cache_checker.sv.
`timescale 1ns / 1ps

module tb_inode_cache_lookup_allocate;
    import inoc_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 9;
    localparam int IDLE_LIMIT     = 20000;
    localparam int HOLDOFF_AFTER  = 800;
    localparam int HOLDOFF_CYCLES = 3000;
    localparam int POOL_SIZE      = 40;
    localparam int DRAIN_CYCLES   = 100;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        req_valid   = 1'b0;
    logic        req_ready;
    t_req        req         = '0;
    logic        rsp_valid;
    logic        rsp_ready   = 1'b0;
    t_rsp        rsp;
    int          fail_count;
    int          pending;
    int          rsp_seen    = 0;
    int          idle_count  = 0;
    logic [31:0] number_pool [POOL_SIZE];

    always #HALF_PERIOD clk = ~clk;

    inode_cache_lookup_allocate i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req_valid   (req_valid),
        .o_req_ready   (req_ready),
        .i_req         (req),
        .o_rsp_valid   (rsp_valid),
        .i_rsp_ready   (rsp_ready),
        .o_rsp         (rsp)
    );

    inode_cache_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req_valid   (req_valid),
        .i_req_ready   (req_ready),
        .i_req         (req),
        .i_rsp_valid   (rsp_valid),
        .i_rsp_ready   (rsp_ready),
        .i_rsp         (rsp),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // watchdog: cycles with no handshake on either channel
    always @(posedge clk) begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
            if (idle_count >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
        if (rsp_valid && rsp_ready)
            rsp_seen <= rsp_seen + 1;
    end

    task automatic send_req(t_req r);
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic send_fields(t_op op, logic [31:0] number, logic [5:0] slot);
        t_req r;
        r.op           = op;
        r.inode_number = number;
        r.slot_index   = slot;
        send_req(r);
    endtask

    task automatic pause_sender(int cycles);
        @(negedge clk);
        req_valid <= 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    // stop offering and wait for every outstanding response
    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_area_start(logic [31:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // mostly gets on a pool of known numbers so hits pile up; fresh numbers fill the table
    function automatic t_req random_req();
        t_req r;
        int   pick;
        r.inode_number = $urandom;
        r.slot_index   = 6'($urandom_range(0, 63));
        pick           = $urandom_range(0, 99);
        if (pick < 20) begin
            r.op = OP_MARK;
        end else begin
            r.op = OP_GET;
            if (pick < 92)
                r.inode_number = number_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return r;
    endfunction

    task automatic run_phase(int count, int pause_at);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 30);
            repeat (burst) begin
                if (sent < count) begin
                    send_req(random_req());
                    sent++;
                    if (sent == pause_at)
                        drain();
                end
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
                pause_sender(gap);
        end
    endtask

    // response side: stall patterns in runs, plus one long hold-off
    initial begin
        int  mode;
        int  run;
        int  tick;
        bit  holdoff_done;
        tick         = 0;
        holdoff_done = 1'b0;
        @(posedge rst_n);
        forever begin
            if (!holdoff_done && rsp_seen >= HOLDOFF_AFTER) begin
                holdoff_done = 1'b1;
                repeat (HOLDOFF_CYCLES)
                    @(negedge clk) rsp_ready <= 1'b0;
            end
            mode = $urandom_range(0, 3);
            run  = $urandom_range(20, 300);
            repeat (run) begin
                @(negedge clk);
                tick++;
                case (mode)
                    0: begin
                        rsp_ready <= 1'b1;
                    end
                    1: begin
                        rsp_ready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        rsp_ready <= (tick % 5) < 3;
                    end
                    default: begin
                        rsp_ready <= ($urandom_range(0, 7) != 0);
                    end
                endcase
            end
        end
    end

    initial begin
        number_pool[0] = 32'h0000_0000;
        number_pool[1] = 32'hFFFF_FFFF;
        number_pool[2] = 32'h0000_0007;
        number_pool[3] = 32'hFFFF_FFF8;
        for (int i = 4; i < POOL_SIZE; i++)
            number_pool[i] = (i % 3 == 0) ? 32'($urandom_range(0, 255)) : $urandom;

        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        write_area_start(32'h0000_0000);
        send_fields(OP_GET,  32'h0000_0000, 6'd0);    // number 0 on an empty table: claim
        send_fields(OP_GET,  32'h0000_0000, 6'd63);   // hit, not loaded
        send_fields(OP_MARK, 32'hFFFF_FFFF, 6'd0);
        send_fields(OP_GET,  32'h0000_0000, 6'd0);    // hit, loaded
        send_fields(OP_GET,  32'hFFFF_FFFF, 6'd0);
        send_fields(OP_MARK, 32'h0000_0000, 6'd63);   // mark on a free slot
        send_fields(OP_GET,  32'h0000_0007, 6'd0);
        send_fields(OP_GET,  32'h0000_0008, 6'd0);
        drain();
        write_area_start(32'hFFFF_FFFF);              // block address wraps
        send_fields(OP_GET,  32'hFFFF_FFFF, 6'd0);
        send_fields(OP_MARK, 32'h0000_0000, 6'd1);
        send_fields(OP_GET,  32'hFFFF_FFFF, 6'd0);
        send_fields(OP_GET,  32'h8000_0001, 6'd0);
        send_fields(OP_MARK, 32'h0000_0000, 6'd3);
        drain();
        write_area_start(32'h0000_1000);
        send_fields(OP_GET,  32'h5555_5555, 6'h15);
        send_fields(OP_GET,  32'hAAAA_AAAA, 6'h2A);
        send_fields(OP_MARK, 32'h0000_0000, 6'd2);
        send_fields(OP_GET,  32'h0000_0007, 6'd0);
        send_fields(OP_MARK, 32'h0000_0000, 6'd62);
        send_fields(OP_GET,  32'h0000_0000, 6'd0);
        send_fields(OP_MARK, 32'h0000_0000, 6'd5);

        drain();
        write_area_start($urandom);
        run_phase(480, 250);
        drain();
        write_area_start(32'h0000_0000);
        run_phase(450, 0);
        drain();
        write_area_start(32'hFFFF_FFFF);
        run_phase(450, 0);
        drain();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
